/* rtl/amdfs_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants for the adjacency matrix depth-first walker
// no dependencies

package amdfs_pkg;

	// field widths fixed by the item format
	localparam int VTX_W     = 5;
	localparam int VCOUNT_W  = 6;
	localparam int VTX_SPAN  = 1 << VTX_W;
	localparam int PDATA_W   = 32;
	localparam int PADDR_W   = 3;

	// opcodes
	localparam logic OP_ADD_EDGE = 1'b0;
	localparam logic OP_WALK     = 1'b1;

	// register index, taken from paddr[2]
	localparam logic REG_VERTEX_COUNT = 1'b0;

	localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 6'd32;

	// controller to datapath commands
	typedef struct packed {
		logic add_edge;
		logic start;
		logic push;
		logic pop;
		logic emit_pend;
		logic emit_last;
		logic emit_bad;
	} ctl_t;

	// datapath to controller status
	typedef struct packed {
		logic is_walk;
		logic start_ok;
		logic found;
		logic depth_one;
		logic slot_free;
	} stat_t;

endpackage

/* rtl/amdfs_if.sv */
`timescale 1ns / 1ps
// command and result channel interfaces for the depth-first walker
// depends on amdfs_pkg

interface amdfs_cmd_if;
	import amdfs_pkg::*;

	logic             valid;
	logic             ready;
	logic             opcode;
	logic [VTX_W-1:0] vertex_a;
	logic [VTX_W-1:0] vertex_b;

	modport source (output valid, opcode, vertex_a, vertex_b, input ready);
	modport sink (input valid, opcode, vertex_a, vertex_b, output ready);
endinterface

interface amdfs_walk_if;
	import amdfs_pkg::*;

	logic             valid;
	logic             ready;
	logic [VTX_W-1:0] visited_vertex;
	logic             last_of_walk;
	logic             bad_start;

	modport source (output valid, visited_vertex, last_of_walk, bad_start, input ready);
	modport sink (input valid, visited_vertex, last_of_walk, bad_start, output ready);
endinterface

/* rtl/amdfs_ctrl.sv */
`timescale 1ns / 1ps
// controller state machine for the depth-first walker
// depends on amdfs_pkg; drives the datapath through ctl_t

module amdfs_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  amdfs_pkg::stat_t stat,
	output amdfs_pkg::ctl_t  ctl
);
	import amdfs_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_RUN  = 3'b010,
		S_BAD  = 3'b100
	} state_t;

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		ctl     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (!stat.is_walk) begin
						ctl.add_edge = 1'b1;
					end else if (stat.start_ok) begin
						ctl.start = 1'b1;
						state_d   = S_RUN;
					end else begin
						state_d = S_BAD;
					end
				end
			end
			S_BAD: begin
				if (stat.slot_free) begin
					ctl.emit_bad = 1'b1;
					state_d      = S_IDLE;
				end
			end
			S_RUN: begin
				if (stat.found) begin
					// descend: previous pending vertex goes out
					if (stat.slot_free) begin
						ctl.push      = 1'b1;
						ctl.emit_pend = 1'b1;
					end
				end else if (stat.depth_one) begin
					// stack empties: pending vertex is the final beat
					if (stat.slot_free) begin
						ctl.pop       = 1'b1;
						ctl.emit_pend = 1'b1;
						ctl.emit_last = 1'b1;
						state_d       = S_IDLE;
					end
				end else begin
					ctl.pop = 1'b1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

/* rtl/amdfs_dp.sv */
`timescale 1ns / 1ps
// datapath: adjacency matrix, visited marks, vertex stack, lowest-neighbour
// encoder and result register; depends on amdfs_pkg

module amdfs_dp #(
	parameter int MAX_VERTICES = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [amdfs_pkg::VCOUNT_W-1:0]   vcount,
	input  logic                             opcode,
	input  logic [amdfs_pkg::VTX_W-1:0]      vertex_a,
	input  logic [amdfs_pkg::VTX_W-1:0]      vertex_b,
	input  amdfs_pkg::ctl_t                  ctl,
	output amdfs_pkg::stat_t                 stat,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [amdfs_pkg::VTX_W-1:0]      visited_vertex,
	output logic                             last_of_walk,
	output logic                             bad_start
);
	import amdfs_pkg::*;

	// vertices reachable through the 5-bit fields
	localparam int NV = (MAX_VERTICES < VTX_SPAN) ? MAX_VERTICES : VTX_SPAN;
	localparam int VW = $clog2(NV);
	localparam int DW = $clog2(NV + 1);
	localparam logic [VCOUNT_W:0] MAX_L = (VCOUNT_W + 1)'(MAX_VERTICES);

	logic [NV-1:0] rows_q [NV];
	logic [NV-1:0] visited_q;
	logic [VW-1:0] stack_q [NV];
	logic [VW-1:0] top_q;
	logic [VW-1:0] pend_q;
	logic [DW-1:0] depth_q;

	logic          a_ok, b_ok;
	logic [VW-1:0] a_idx, b_idx;
	logic [NV-1:0] live;
	logic [NV-1:0] cand;
	logic [VW-1:0] sel;
	logic [DW-1:0] push_d, below_d;

	// range checks against the effective count
	assign a_ok  = ((VCOUNT_W + 1)'(vertex_a) < (VCOUNT_W + 1)'(vcount))
		&& ((VCOUNT_W + 1)'(vertex_a) < MAX_L);
	assign b_ok  = ((VCOUNT_W + 1)'(vertex_b) < (VCOUNT_W + 1)'(vcount))
		&& ((VCOUNT_W + 1)'(vertex_b) < MAX_L);
	assign a_idx = vertex_a[VW-1:0];
	assign b_idx = vertex_b[VW-1:0];

	// vertices below the live count
	always_comb begin
		for (int u = 0; u < NV; u++) begin
			live[u] = ((VCOUNT_W + 1)'(u) < (VCOUNT_W + 1)'(vcount));
		end
	end

	// unvisited live neighbours of the top vertex, lowest first
	assign cand = rows_q[top_q] & live & ~visited_q;

	always_comb begin
		sel = '0;
		for (int u = NV - 1; u >= 0; u--) begin
			if (cand[u]) begin
				sel = VW'(u);
			end
		end
	end

	assign push_d  = depth_q - DW'(1);
	assign below_d = depth_q - DW'(2);

	// status back to the controller
	assign stat.is_walk   = (opcode == OP_WALK);
	assign stat.start_ok  = a_ok;
	assign stat.found     = |cand;
	assign stat.depth_one = (depth_q == DW'(1));
	assign stat.slot_free = !out_valid || out_ready;

	// adjacency matrix, symmetric bits set together
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < NV; r++) begin
				rows_q[r] <= '0;
			end
		end else if (ctl.add_edge && a_ok && b_ok) begin
			rows_q[a_idx][b_idx] <= 1'b1;
			rows_q[b_idx][a_idx] <= 1'b1;
		end
	end

	// visited marks and stack depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			visited_q <= '0;
			depth_q   <= '0;
		end else if (ctl.start) begin
			visited_q <= {{(NV - 1){1'b0}}, 1'b1} << a_idx;
			depth_q   <= DW'(1);
		end else if (ctl.push) begin
			visited_q[sel] <= 1'b1;
			depth_q        <= depth_q + DW'(1);
		end else if (ctl.pop) begin
			depth_q <= depth_q - DW'(1);
		end
	end

	// stack below the top, top vertex and the vertex awaiting output
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			top_q  <= a_idx;
			pend_q <= a_idx;
		end else if (ctl.push) begin
			stack_q[push_d[VW-1:0]] <= top_q;
			top_q                   <= sel;
			pend_q                  <= sel;
		end else if (ctl.pop && !stat.depth_one) begin
			top_q <= stack_q[below_d[VW-1:0]];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (ctl.emit_pend || ctl.emit_bad) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit_bad) begin
			visited_vertex <= '0;
			last_of_walk   <= 1'b1;
			bad_start      <= 1'b1;
		end else if (ctl.emit_pend) begin
			visited_vertex <= VTX_W'(pend_q);
			last_of_walk   <= ctl.emit_last;
			bad_start      <= 1'b0;
		end
	end

endmodule

/* rtl/adjacency_matrix_dfs_order.sv */
`timescale 1ns / 1ps
// Depth-first walker over an undirected adjacency bit matrix.
// Channels: cmd (sink) carries opcode, vertex_a, vertex_b; walk (source)
// carries visited_vertex, last_of_walk, bad_start. A beat moves when valid
// and ready are both high. Register vertex_count sits on an APB port at
// byte address 0; the user must write it only while the block is idle,
// which the block itself does not enforce. An add-edge beat gives no
// result and the block is ready again in the next cycle. A traverse beat
// emits one beat per visited vertex in depth-first order, the final one
// flagged last_of_walk. A walk takes one step per push and one per pop of
// the vertex stack: each step reads one matrix row and runs one lowest-bit
// encoder. A visited vertex waits in a pending register until the next
// push or the end of the walk, and its beat appears in the result register
// in the cycle after that. A bad start vertex gives a single beat, passing
// through the bad state and then the result register.
// cmd is ready only between walks. A stalled walk channel holds every
// step that emits a beat, while steps that only pop go on; nothing is dropped.
// Reset clears the matrix, the visited marks, the stack depth and the
// result valid flag, and sets vertex_count to 32.
// depends on amdfs_pkg, amdfs_if, amdfs_ctrl, amdfs_dp

module adjacency_matrix_dfs_order #(
	parameter int MAX_VERTICES = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	amdfs_cmd_if.sink                       cmd,
	amdfs_walk_if.source                    walk,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [amdfs_pkg::PADDR_W-1:0]   paddr,
	input  logic [amdfs_pkg::PDATA_W-1:0]   pwdata,
	output logic [amdfs_pkg::PDATA_W-1:0]   prdata,
	output logic                            pready
);
	import amdfs_pkg::*;

	logic [VCOUNT_W-1:0] vcount_q;
	ctl_t                ctl;
	stat_t               stat;

	// configuration register
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= VCOUNT_RESET;
		end else if (psel && penable && pwrite && pready
			&& (paddr[2] == REG_VERTEX_COUNT)) begin
			vcount_q <= pwdata[VCOUNT_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_VERTEX_COUNT) ? PDATA_W'(vcount_q) : '0;

	amdfs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmd.valid),
		.in_ready (cmd.ready),
		.stat     (stat),
		.ctl      (ctl)
	);

	amdfs_dp #(
		.MAX_VERTICES (MAX_VERTICES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.vcount         (vcount_q),
		.opcode         (cmd.opcode),
		.vertex_a       (cmd.vertex_a),
		.vertex_b       (cmd.vertex_b),
		.ctl            (ctl),
		.stat           (stat),
		.out_valid      (walk.valid),
		.out_ready      (walk.ready),
		.visited_vertex (walk.visited_vertex),
		.last_of_walk   (walk.last_of_walk),
		.bad_start      (walk.bad_start)
	);

endmodule

/* rtl/amdfs_checker.sv */
`timescale 1ns / 1ps
// port-level checks for the depth-first walker, bound to the top level
// depends on amdfs_pkg and adjacency_matrix_dfs_order

module amdfs_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         cmd_valid,
	input logic                         cmd_ready,
	input logic                         cmd_opcode,
	input logic                         walk_valid,
	input logic                         walk_ready,
	input logic [amdfs_pkg::VTX_W-1:0]  walk_vertex,
	input logic                         walk_last,
	input logic                         walk_bad
);
	import amdfs_pkg::*;

	// a stalled result beat holds
	a_walk_hold: assert property (@(posedge clk) disable iff (!arst_n)
		walk_valid && !walk_ready |=> walk_valid && $stable(walk_vertex)
		&& $stable(walk_last) && $stable(walk_bad))
		else $error("walk beat changed while stalled");

	// a bad start is a lone beat with vertex zero
	a_bad_alone: assert property (@(posedge clk) disable iff (!arst_n)
		walk_valid && walk_bad |-> walk_last && (walk_vertex == '0))
		else $error("bad start beat not final or vertex not zero");

	// no new command while a walk is still being delivered
	a_busy_walk: assert property (@(posedge clk) disable iff (!arst_n)
		walk_valid && !walk_last |-> !cmd_ready)
		else $error("command taken in the middle of a walk");

	// an add-edge beat leaves the block ready in the next cycle
	a_edge_quick: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && (cmd_opcode == OP_ADD_EDGE) |=> cmd_ready)
		else $error("add-edge left the block busy");

endmodule

bind adjacency_matrix_dfs_order amdfs_checker u_amdfs_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.cmd_valid   (cmd.valid),
	.cmd_ready   (cmd.ready),
	.cmd_opcode  (cmd.opcode),
	.walk_valid  (walk.valid),
	.walk_ready  (walk.ready),
	.walk_vertex (walk.visited_vertex),
	.walk_last   (walk.last_of_walk),
	.walk_bad    (walk.bad_start)
);

/* test/adjacency_matrix_dfs_order_test.sv */
`timescale 1ns / 1ps
// self-checking bench for the adjacency matrix depth-first walker: edges and walks
// go in on the command channel and visit order is checked beat by beat on the walk channel
// depends on amdfs_pkg, amdfs_if and adjacency_matrix_dfs_order

module adjacency_matrix_dfs_order_test;
	import amdfs_pkg::*;

	localparam int MAX_VERTICES  = 32;
	localparam int SETTLE_CYCLES = 80;
	localparam int ERR_SHOWN     = 50;
	localparam logic [PADDR_W-1:0] ADDR_VERTEX_COUNT = {REG_VERTEX_COUNT, 2'b00};
	localparam logic [PADDR_W-1:0] ADDR_UNMAPPED     = 3'd4;

	typedef struct packed {
		logic             op;
		logic [VTX_W-1:0] a;
		logic [VTX_W-1:0] b;
	} cmd_beat_t;

	typedef struct packed {
		logic [VTX_W-1:0] vertex;
		logic             last;
		logic             bad;
	} walk_beat_t;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [PDATA_W-1:0]  pwdata;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	amdfs_cmd_if  cmd_ch ();
	amdfs_walk_if walk_ch ();

	adjacency_matrix_dfs_order #(
		.MAX_VERTICES(MAX_VERTICES)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.walk(walk_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// graph shadow and pending visit order
	logic [MAX_VERTICES-1:0] adj_rows [MAX_VERTICES];
	logic [VCOUNT_W-1:0]     vcount_shadow;
	cmd_beat_t               item_q [$];
	walk_beat_t              visit_q [$];

	int  cmds_sent;
	int  cmds_taken;
	int  errors;
	int  edges_taken;
	int  walks_taken;
	int  bad_walks;
	int  beats_seen;
	bit  steady;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("timeout with %0d beats still expected", visit_q.size());
		$display("simulation failed");
		$finish;
	end

	function automatic int live_count();
		return (vcount_shadow > MAX_VERTICES) ? MAX_VERTICES : int'(vcount_shadow);
	endfunction

	function automatic logic [MAX_VERTICES-1:0] low_mask(input int n);
		logic [63:0] m;
		m = (64'd1 << n) - 64'd1;
		return m[MAX_VERTICES-1:0];
	endfunction

	function automatic void add_edge(input logic [VTX_W-1:0] a, input logic [VTX_W-1:0] b);
		int n;
		n = live_count();
		// edges touching a vertex outside the live range are dropped
		if (a < n && b < n) begin
			adj_rows[a][b] = 1'b1;
			adj_rows[b][a] = 1'b1;
		end
	endfunction

	// depth-first walk with an explicit stack, lowest neighbour first
	function automatic void walk_from(input logic [VTX_W-1:0] start);
		logic [VTX_W-1:0]        stk_vertex [MAX_VERTICES];
		logic [VCOUNT_W-1:0]     stk_next [MAX_VERTICES];
		logic [MAX_VERTICES-1:0] seen;
		logic [MAX_VERTICES-1:0] cand;
		logic [MAX_VERTICES-1:0] live;
		walk_beat_t              beat;
		int                      n;
		int                      depth;
		int                      top;
		int                      pick;
		n = live_count();
		live = low_mask(n);
		beat.bad = 1'b0;
		beat.last = 1'b0;
		if (start >= n) begin
			beat.vertex = '0;
			beat.last = 1'b1;
			beat.bad = 1'b1;
			visit_q.push_back(beat);
			bad_walks++;
			return;
		end
		seen = '0;
		seen[start] = 1'b1;
		stk_vertex[0] = start;
		stk_next[0] = '0;
		depth = 1;
		beat.vertex = start;
		visit_q.push_back(beat);
		while (depth > 0) begin
			top = depth - 1;
			cand = adj_rows[stk_vertex[top]] & live & ~seen & ~low_mask(stk_next[top]);
			pick = -1;
			for (int i = MAX_VERTICES - 1; i >= 0; i--)
				if (cand[i])
					pick = i;
			if (pick >= 0 && depth < MAX_VERTICES) begin
				stk_next[top] = VCOUNT_W'(pick + 1);
				seen[pick] = 1'b1;
				stk_vertex[depth] = VTX_W'(pick);
				stk_next[depth] = '0;
				depth++;
				beat.vertex = VTX_W'(pick);
				visit_q.push_back(beat);
			end else begin
				depth--;
			end
		end
		visit_q[visit_q.size() - 1].last = 1'b1;
	endfunction

	function automatic void check_field(input string field, input int want, input int got);
		if (want != got) begin
			errors++;
			if (errors <= ERR_SHOWN)
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
		end
	endfunction

	// sample both channels; predict on command beats, check on walk beats
	always @(posedge clk) begin : monitor
		walk_beat_t want;
		if (arst_n) begin
			if (cmd_ch.valid && cmd_ch.ready) begin
				cmds_taken++;
				if (cmd_ch.opcode == OP_WALK) begin
					walks_taken++;
					walk_from(cmd_ch.vertex_a);
				end else begin
					edges_taken++;
					add_edge(cmd_ch.vertex_a, cmd_ch.vertex_b);
				end
			end
			if (walk_ch.valid && walk_ch.ready) begin
				beats_seen++;
				if (visit_q.size() == 0) begin
					errors++;
					if (errors <= ERR_SHOWN)
						$display("%0t: unexpected beat, expected none, got vertex %0d last %0b bad %0b",
							$time, walk_ch.visited_vertex, walk_ch.last_of_walk,
							walk_ch.bad_start);
				end else begin
					want = visit_q.pop_front();
					check_field("visited_vertex", want.vertex, walk_ch.visited_vertex);
					check_field("last_of_walk", want.last, walk_ch.last_of_walk);
					check_field("bad_start", want.bad, walk_ch.bad_start);
				end
			end
		end
	end

	// drive the command channel and the walk ready at the falling edge
	always @(negedge clk) begin : driver
		cmd_beat_t it;
		if (arst_n) begin
			if (!cmd_ch.valid || cmds_taken == cmds_sent) begin
				if (item_q.size() != 0 && (steady || $urandom_range(99) >= 9)) begin
					it = item_q.pop_front();
					cmd_ch.valid <= 1'b1;
					cmd_ch.opcode <= it.op;
					cmd_ch.vertex_a <= it.a;
					cmd_ch.vertex_b <= it.b;
					cmds_sent++;
				end else begin
					cmd_ch.valid <= 1'b0;
				end
			end
			walk_ch.ready <= steady || ($urandom_range(99) >= 9);
		end
	end

	task automatic queue_item(input logic op, input int a, input int b);
		cmd_beat_t it;
		it.op = op;
		it.a = VTX_W'(a);
		it.b = VTX_W'(b);
		item_q.push_back(it);
	endtask

	function automatic logic [VTX_W-1:0] pick_vertex(input int n);
		if (n > 0 && $urandom_range(99) < 85)
			return VTX_W'($urandom_range(n - 1));
		return VTX_W'($urandom_range(VTX_SPAN - 1));
	endfunction

	task automatic queue_random(input int count, input int walk_pct);
		int n;
		n = live_count();
		repeat (count) begin
			queue_item(($urandom_range(99) < walk_pct) ? OP_WALK : OP_ADD_EDGE,
				pick_vertex(n), pick_vertex(n));
		end
	endtask

	// hold the sender until every queued beat is in and every visit is back
	task automatic drain();
		while (item_q.size() != 0 || cmds_taken != cmds_sent || visit_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (addr == ADDR_VERTEX_COUNT)
			vcount_shadow = data[VCOUNT_W-1:0];
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic check_vcount();
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= ADDR_VERTEX_COUNT;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		check_field("vertex_count readback", vcount_shadow, prdata[VCOUNT_W-1:0]);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_vcount(input int value);
		drain();
		reg_write(ADDR_VERTEX_COUNT, PDATA_W'(value));
		check_vcount();
	endtask

	initial begin : stimulus
		int phase_vcount [8];
		phase_vcount = '{6, 32, 12, 2, 33, 20, 32, 9};

		// every input known from time zero
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cmd_ch.valid = 1'b0;
		cmd_ch.opcode = OP_ADD_EDGE;
		cmd_ch.vertex_a = '0;
		cmd_ch.vertex_b = '0;
		walk_ch.ready = 1'b0;
		steady = 1'b0;
		vcount_shadow = VCOUNT_RESET;
		foreach (adj_rows[i])
			adj_rows[i] = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		check_vcount();

		// empty graph, then a small graph with a self loop
		queue_item(OP_WALK, 0, 31);
		queue_item(OP_WALK, 31, 0);
		queue_item(OP_ADD_EDGE, 0, 31);
		queue_item(OP_ADD_EDGE, 5, 5);
		queue_item(OP_ADD_EDGE, 5, 6);
		queue_item(OP_ADD_EDGE, 6, 31);
		queue_item(OP_ADD_EDGE, 31, 2);
		queue_item(OP_ADD_EDGE, 3, 4);
		queue_item(OP_WALK, 0, 0);
		queue_item(OP_WALK, 5, 0);
		queue_item(OP_WALK, 3, 0);

		// single vertex: bad starts and a dropped edge
		set_vcount(1);
		queue_item(OP_WALK, 0, 0);
		queue_item(OP_WALK, 1, 0);
		queue_item(OP_ADD_EDGE, 0, 1);
		queue_item(OP_ADD_EDGE, 0, 0);
		queue_item(OP_WALK, 0, 0);
		queue_item(OP_WALK, 31, 0);

		// no vertices at all, plus a write to an unmapped register
		set_vcount(0);
		queue_item(OP_WALK, 0, 0);
		queue_item(OP_ADD_EDGE, 0, 0);
		drain();
		reg_write(ADDR_UNMAPPED, 32'd7);
		check_vcount();
		queue_item(OP_WALK, 0, 0);

		// count above the maximum saturates
		set_vcount(63);
		queue_item(OP_WALK, 31, 0);
		queue_item(OP_ADD_EDGE, 31, 30);
		queue_item(OP_WALK, 30, 0);

		// random phases over several counts, lowered and raised again
		foreach (phase_vcount[p]) begin
			set_vcount(phase_vcount[p]);
			steady = (p == 1);
			queue_random(25, 40);
		end

		drain();
		$display("%0d edge and %0d walk commands (%0d bad starts), %0d visit beats checked",
			edges_taken, walks_taken, bad_walks, beats_seen);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
